### sv/rbds_pkg.sv
// rbds_pkg: shared types and constants of the radar best-detection selector
// no dependencies; used by radar_best_detection_select_top
package rbds_pkg;

	localparam int NUM_SENSORS = 3;
	localparam int MAX_POINTS  = 5;

	localparam int DIST_W   = 32;
	localparam int SNR_W    = 20;
	localparam int MM_W     = 16;
	localparam int SNR_INT_W = 16;
	localparam int SENSOR_W = 2;
	localparam int MODE_W   = 2;
	localparam int EVENT_W  = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 20;

	localparam logic [MM_W-1:0]  VOID_MM        = 16'hFFFF;
	localparam logic [9:0]       MM_PER_M       = 10'd1000;
	localparam logic [SNR_W-1:0] SNR_THR_RESET  = 20'd800;
	localparam logic [1:0]       MIN_HEALTHY_RESET = 2'd2;

	typedef enum logic [MODE_W-1:0] {
		MODE_POINT   = 2'd0,
		MODE_EMPTY   = 2'd1,
		MODE_OFFLINE = 2'd2,
		MODE_NONE    = 2'd3
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ENABLE      = 2'd0,
		REG_SNR_THR     = 2'd1,
		REG_MIN_HEALTHY = 2'd2,
		REG_UNUSED      = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [MODE_W-1:0]   mode;
		logic [SENSOR_W-1:0] sensor;
		logic [DIST_W-1:0]   point_range;
		logic [SNR_W-1:0]    snr;
		logic                last_point;
		logic                chirping;
		logic                link_healthy;
	} item_t;

	function automatic logic [MM_W-1:0] to_mm(input logic signed [DIST_W-1:0] d);
		logic [DIST_W+9-1:0] prod;
		prod = {10'd0, d[DIST_W-2:0]} * {{(DIST_W-1){1'b0}}, MM_PER_M};
		if (d[DIST_W-1] || d == '0) begin
			return '0;
		end else if (|prod[DIST_W+9-1:32]) begin
			return VOID_MM;
		end else begin
			return prod[31:16];
		end
	endfunction

endpackage

### sv/radar_best_detection_select_top.sv
// radar_best_detection_select_top: best-point selection, per-sensor store and health
// depends on rbds_pkg
//
//  channel | signals                          | direction | transfer when
//  --------+----------------------------------+-----------+---------------------------
//  input   | in_valid, in_stall, item fields  | in        | in_valid && !in_stall
//  output  | out_valid, out_stall, res fields | out       | out_valid && !out_stall
//  config  | cfg_valid, cfg_ready, index,data | in        | cfg_valid && cfg_ready
//
// one item per cycle unless the output stalls
// an input register feeds the selection logic, which writes the result register
// and the frame and sensor state at the same edge
// an output stall holds the result and, once the input register is full, the input
// arst_n clears config to reset values, the frame, sensor and event state and both valid flags
module radar_best_detection_select_top #(
	parameter int NUM_SENSORS = rbds_pkg::NUM_SENSORS,
	parameter int MAX_POINTS  = rbds_pkg::MAX_POINTS
) (
	input  logic clk,
	input  logic arst_n,

	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [rbds_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rbds_pkg::CFG_DATA_W-1:0]  cfg_data,

	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [rbds_pkg::MODE_W-1:0]      mode,
	input  logic [rbds_pkg::SENSOR_W-1:0]    sensor,
	input  logic signed [rbds_pkg::DIST_W-1:0] point_range,
	input  logic [rbds_pkg::SNR_W-1:0]       snr,
	input  logic                             last_point,
	input  logic                             chirping,
	input  logic                             link_healthy,

	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [rbds_pkg::SENSOR_W-1:0]    sensor_out,
	output logic [rbds_pkg::MM_W-1:0]        range_mm,
	output logic [rbds_pkg::SNR_INT_W-1:0]   snr_int,
	output logic                             valid_res,
	output logic                             accepted,
	output logic [1:0]                       live_sensors,
	output logic                             healthy,
	output logic [rbds_pkg::EVENT_W-1:0]     update_total
);

	localparam int IDX_W = $clog2(MAX_POINTS + 1);

	// configuration
	logic                          enable_q;
	logic [rbds_pkg::SNR_W-1:0]    snr_thr_q;
	logic [1:0]                    min_healthy_q;

	// input register
	logic            valid_s1;
	rbds_pkg::item_t item_s1;

	// frame accumulator
	logic [IDX_W-1:0]             idx_q;
	logic                         best_found_q;
	logic [rbds_pkg::MM_W-1:0]    best_dist_q;
	logic [rbds_pkg::SNR_W-1:0]   best_snr_q;

	// per-sensor store
	logic [rbds_pkg::MM_W-1:0]      sens_dist_q  [NUM_SENSORS];
	logic [rbds_pkg::SNR_INT_W-1:0] sens_snr_q   [NUM_SENSORS];
	logic [NUM_SENSORS-1:0]         sens_valid_q;

	logic                          count_valid_q;
	logic [1:0]                    count_q;
	logic                          health_q;
	logic [rbds_pkg::EVENT_W-1:0]  events_q;

	// result register
	logic                            out_valid_q;
	logic [rbds_pkg::SENSOR_W-1:0]   res_sensor_q;
	logic [rbds_pkg::MM_W-1:0]       res_dist_q;
	logic [rbds_pkg::SNR_INT_W-1:0]  res_snr_q;
	logic                            res_valid_q;
	logic                            res_acc_q;

	logic adv;
	logic take;
	logic fire;
	logic in_window;
	logic qual;
	logic [rbds_pkg::MM_W-1:0]    mm;
	logic                         nb_found;
	logic [rbds_pkg::MM_W-1:0]    nb_dist;
	logic [rbds_pkg::SNR_W-1:0]   nb_snr;
	logic [IDX_W-1:0]             n_idx;
	logic                         n_found;
	logic [rbds_pkg::MM_W-1:0]    n_bdist;
	logic [rbds_pkg::SNR_W-1:0]   n_bsnr;
	logic                         wr_store;
	logic                         wr_snr_only;
	logic [rbds_pkg::MM_W-1:0]    w_dist;
	logic [rbds_pkg::SNR_INT_W-1:0] w_snr;
	logic                         w_valid;
	logic                         acc;
	logic                         has_res;
	logic [NUM_SENSORS-1:0]       sel;
	logic [NUM_SENSORS-1:0]       n_valid;
	logic [rbds_pkg::MM_W-1:0]    rd_dist;
	logic [rbds_pkg::SNR_INT_W-1:0] rd_snr;
	logic [2:0]                   n_cnt;
	logic [1:0]                   n_cnt_sat;

	assign cfg_ready = 1'b1;

	assign adv      = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !adv;
	assign take     = in_valid && !in_stall;

	assign fire = valid_s1 && adv && enable_q
		&& (item_s1.mode != rbds_pkg::MODE_NONE)
		&& (32'(item_s1.sensor) < NUM_SENSORS);

	assign mm        = rbds_pkg::to_mm(item_s1.point_range);
	assign in_window = idx_q < IDX_W'(MAX_POINTS);
	assign qual      = in_window && (item_s1.snr >= snr_thr_q)
		&& (!best_found_q || item_s1.snr > best_snr_q);
	assign nb_found  = best_found_q || qual;
	assign nb_dist   = qual ? mm : best_dist_q;
	assign nb_snr    = qual ? item_s1.snr : best_snr_q;

	always_comb begin
		n_idx       = idx_q;
		n_found     = best_found_q;
		n_bdist     = best_dist_q;
		n_bsnr      = best_snr_q;
		wr_store    = 1'b0;
		wr_snr_only = 1'b0;
		w_dist      = rbds_pkg::VOID_MM;
		w_snr       = '0;
		w_valid     = 1'b0;
		acc         = 1'b0;
		has_res     = 1'b0;
		unique case (item_s1.mode)
			rbds_pkg::MODE_POINT: begin
				if (item_s1.last_point) begin
					n_idx    = '0;
					n_found  = 1'b0;
					n_bdist  = '0;
					n_bsnr   = '0;
					wr_store = 1'b1;
					w_dist   = nb_found ? nb_dist : rbds_pkg::VOID_MM;
					w_snr    = nb_found ? nb_snr[rbds_pkg::SNR_W-1:4] : '0;
					w_valid  = 1'b1;
					acc      = 1'b1;
					has_res  = 1'b1;
				end else begin
					n_idx   = in_window ? idx_q + IDX_W'(1) : idx_q;
					n_found = nb_found;
					n_bdist = nb_dist;
					n_bsnr  = nb_snr;
				end
			end
			rbds_pkg::MODE_EMPTY: begin
				n_idx    = '0;
				n_found  = 1'b0;
				n_bdist  = '0;
				n_bsnr   = '0;
				has_res  = 1'b1;
				wr_store = item_s1.chirping;
				w_valid  = item_s1.chirping;
				acc      = item_s1.chirping;
			end
			rbds_pkg::MODE_OFFLINE: begin
				n_idx       = '0;
				n_found     = 1'b0;
				n_bdist     = '0;
				n_bsnr      = '0;
				has_res     = 1'b1;
				wr_snr_only = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		n_valid = sens_valid_q;
		rd_dist = '0;
		rd_snr  = '0;
		n_cnt   = '0;
		for (int i = 0; i < NUM_SENSORS; i++) begin
			sel[i] = (32'(item_s1.sensor) == i);
			if (sel[i] && has_res) begin
				n_valid[i] = w_valid;
			end
			if (sel[i]) begin
				rd_dist = sens_dist_q[i];
				rd_snr  = sens_snr_q[i];
			end
		end
		for (int i = 0; i < NUM_SENSORS; i++) begin
			n_cnt = n_cnt + 3'(n_valid[i]);
		end
		n_cnt_sat = (n_cnt > 3'd3) ? 2'd3 : n_cnt[1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q      <= 1'b0;
			snr_thr_q     <= rbds_pkg::SNR_THR_RESET;
			min_healthy_q <= rbds_pkg::MIN_HEALTHY_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				rbds_pkg::REG_ENABLE:      enable_q      <= cfg_data[0];
				rbds_pkg::REG_SNR_THR:     snr_thr_q     <= cfg_data[rbds_pkg::SNR_W-1:0];
				rbds_pkg::REG_MIN_HEALTHY: min_healthy_q <= cfg_data[1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || adv) begin
			valid_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= '{mode: mode, sensor: sensor, point_range: point_range, snr: snr,
				last_point: last_point, chirping: chirping, link_healthy: link_healthy};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q         <= '0;
			best_found_q  <= 1'b0;
			best_dist_q   <= '0;
			best_snr_q    <= '0;
			sens_valid_q  <= '0;
			count_valid_q <= 1'b0;
			count_q       <= '0;
			health_q      <= 1'b0;
			events_q      <= '0;
			for (int i = 0; i < NUM_SENSORS; i++) begin
				sens_dist_q[i] <= '0;
				sens_snr_q[i]  <= '0;
			end
		end else if (fire) begin
			idx_q        <= n_idx;
			best_found_q <= n_found;
			best_dist_q  <= n_bdist;
			best_snr_q   <= n_bsnr;
			sens_valid_q <= n_valid;
			for (int i = 0; i < NUM_SENSORS; i++) begin
				if (sel[i] && wr_store) begin
					sens_dist_q[i] <= w_dist;
					sens_snr_q[i]  <= w_snr;
				end else if (sel[i] && wr_snr_only) begin
					sens_snr_q[i] <= '0;
				end
			end
			if (acc) begin
				count_valid_q <= 1'b1;
				count_q       <= n_cnt_sat;
				health_q      <= (n_cnt_sat >= min_healthy_q) && item_s1.link_healthy;
				events_q      <= events_q + rbds_pkg::EVENT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= fire && has_res;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && fire && has_res) begin
			res_sensor_q <= item_s1.sensor;
			res_dist_q   <= wr_store ? w_dist : rd_dist;
			res_snr_q    <= (wr_store || wr_snr_only) ? w_snr : rd_snr;
			res_valid_q  <= w_valid;
			res_acc_q    <= acc;
		end
	end

	assign out_valid    = out_valid_q;
	assign sensor_out   = res_sensor_q;
	assign range_mm     = res_dist_q;
	assign snr_int      = res_snr_q;
	assign valid_res    = res_valid_q;
	assign accepted     = res_acc_q;
	assign live_sensors = count_valid_q ? count_q : 2'd0;
	assign healthy      = health_q;
	assign update_total = events_q;

endmodule
